@@ design/ukd_pkg.sv @@
// shared constants, codes and types for the uart key-state debouncer
package ukd_pkg;

	localparam int LineBufferBytes = 32;
	localparam int LineCountW = $clog2(LineBufferBytes);

	localparam logic [15:0] DebounceReset = 16'd50;

	// result status codes
	localparam logic [2:0] ST_PENDING  = 3'd0;
	localparam logic [2:0] ST_DONE     = 3'd1;
	localparam logic [2:0] ST_INVALID  = 3'd2;
	localparam logic [2:0] ST_OVERFLOW = 3'd3;
	localparam logic [2:0] ST_IGNORED  = 3'd4;

	// configuration register indexes
	localparam logic [1:0] CFG_RAW_MODE     = 2'd0;
	localparam logic [1:0] CFG_DEBOUNCE     = 2'd1;
	localparam logic [1:0] CFG_PRESS_ONLY   = 2'd2;

	localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
	localparam logic [7:0] CHAR_PLUS    = 8'h2b;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NINE    = 8'h39;

	// front end decision for one word
	typedef struct packed {
		logic       apply;
		logic [2:0] status;
		logic [3:0] buttons;
	} ukd_parse_t;

	// debounce outcome for one word
	typedef struct packed {
		logic [2:0] mask;
		logic [2:0] levels;
		logic       power;
		logic [2:0] syncs;
		logic       sync;
	} ukd_report_t;

endpackage

@@ design/uart_key_state_debouncer_core.sv @@
// top level: input register, parse and debounce logic, result register, config
// Takes one received UART word (byte plus tick time) per clock while the output is not stalled
// and returns one result word per input. The byte is held in an input register; the line parser
// and the four parallel debounce compares update their state in the same cycle as they fill the
// result register. A word passes the input register, then the result register, and a new word
// can follow every clock while out_ready is high. in_ready stays high while the input register
// is empty or its word moves into the result register, so with the output stalled two words are
// held before the input stalls. Configuration writes are accepted at any time (cfg_ready is tied
// high) but must only be issued while the block is idle; index 0 is raw_mode, 1 debounce_ticks,
// 2 the press-only sync flag, and index 3 is ignored.
module uart_key_state_debouncer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic [31:0] now_ticks,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [2:0]  key_change_mask,
	output logic [2:0]  key_levels,
	output logic        power_changed,
	output logic [2:0]  release_syncs,
	output logic        sync_out,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import ukd_pkg::*;

	logic        raw_mode_q;
	logic [15:0] debounce_ticks_q;
	logic        press_only_q;

	logic        valid_s1;
	logic [7:0]  rx_byte_s1;
	logic [31:0] now_ticks_s1;
	logic        valid_s2;
	logic        advance;

	ukd_parse_t  parse;
	ukd_report_t report;

	logic [2:0]  status_s2;
	ukd_report_t report_s2;

	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_mode_q       <= 1'b0;
			debounce_ticks_q <= DebounceReset;
			press_only_q     <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_RAW_MODE:   raw_mode_q       <= cfg_data[0];
				CFG_DEBOUNCE:   debounce_ticks_q <= cfg_data;
				CFG_PRESS_ONLY: press_only_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_byte_s1   <= rx_byte;
			now_ticks_s1 <= now_ticks;
		end
		if (advance) begin
			status_s2 <= parse.status;
			report_s2 <= parse.apply ? report : '0;
		end
	end

	ukd_line_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.raw_mode (raw_mode_q),
		.rx_byte  (rx_byte_s1),
		.parse    (parse)
	);

	ukd_debounce u_debounce (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (advance),
		.apply          (parse.apply),
		.buttons        (parse.buttons),
		.now_ticks      (now_ticks_s1),
		.debounce_ticks (debounce_ticks_q),
		.press_only     (press_only_q),
		.report         (report)
	);

	assign out_valid       = valid_s2;
	assign status          = status_s2;
	assign key_change_mask = report_s2.mask;
	assign key_levels      = report_s2.levels;
	assign power_changed   = report_s2.power;
	assign release_syncs   = report_s2.syncs;
	assign sync_out        = report_s2.sync;

endmodule

@@ design/ukd_line_parser.sv @@
// byte front end: raw state decode and decimal line assembly
module ukd_line_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              raw_mode,
	input  logic [7:0]        rx_byte,
	output ukd_pkg::ukd_parse_t parse
);
	import ukd_pkg::*;

	logic [LineCountW-1:0] line_count_q, line_count_d;
	logic [31:0]           line_value_q, line_value_d;
	logic                  digit_seen_q, digit_seen_d;
	logic                  text_ended_q, text_ended_d;
	logic                  line_bad_q, line_bad_d;
	logic [35:0]           next_value;
	logic [3:0]            digit;
	logic                  is_digit;
	logic                  first;

	assign digit      = 4'(rx_byte - CHAR_ZERO);
	assign is_digit   = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
	// value * 10 + digit as shifts and adds
	assign next_value = {1'b0, line_value_q, 3'b000} + {3'b000, line_value_q, 1'b0} +
		{32'd0, digit};
	assign first      = (line_count_q == '0);

	always_comb begin
		parse         = '0;
		parse.status  = ST_PENDING;
		parse.buttons = rx_byte[3:0];
		line_count_d  = line_count_q;
		line_value_d  = line_value_q;
		digit_seen_d  = digit_seen_q;
		text_ended_d  = text_ended_q;
		line_bad_d    = line_bad_q;
		if (raw_mode) begin
			// raw bytes leave any partial line alone
			parse.apply  = (rx_byte[7:4] == 4'd0);
			parse.status = parse.apply ? ST_DONE : ST_IGNORED;
		end else if (line_count_q >= LineCountW'(LineBufferBytes - 1)) begin
			parse.status = ST_OVERFLOW;
			line_count_d = '0;
			line_value_d = '0;
			digit_seen_d = 1'b0;
			text_ended_d = 1'b0;
			line_bad_d   = 1'b0;
		end else if (rx_byte == CHAR_NEWLINE) begin
			parse.apply   = digit_seen_q && !line_bad_q;
			parse.status  = parse.apply ? ST_DONE : ST_INVALID;
			parse.buttons = line_value_q[3:0];
			line_count_d  = '0;
			line_value_d  = '0;
			digit_seen_d  = 1'b0;
			text_ended_d  = 1'b0;
			line_bad_d    = 1'b0;
		end else begin
			line_count_d = line_count_q + LineCountW'(1);
			if (!text_ended_q) begin
				if (rx_byte == 8'd0) begin
					text_ended_d = 1'b1;
				end else if (rx_byte == CHAR_PLUS && first) begin
					// leading sign, nothing to record
				end else if (is_digit) begin
					digit_seen_d = 1'b1;
					if (!line_bad_q) begin
						if (next_value[35:32] != 4'd0)
							line_bad_d = 1'b1;
						else
							line_value_d = next_value[31:0];
					end
				end else begin
					line_bad_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q <= '0;
			line_value_q <= '0;
			digit_seen_q <= 1'b0;
			text_ended_q <= 1'b0;
			line_bad_q   <= 1'b0;
		end else if (en) begin
			line_count_q <= line_count_d;
			line_value_q <= line_value_d;
			digit_seen_q <= digit_seen_d;
			text_ended_q <= text_ended_d;
			line_bad_q   <= line_bad_d;
		end
	end

endmodule

@@ design/ukd_debounce.sv @@
// per-button debounce against the time of each button's last report
module ukd_debounce (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 apply,
	input  logic [3:0]           buttons,
	input  logic [31:0]          now_ticks,
	input  logic [15:0]          debounce_ticks,
	input  logic                 press_only,
	output ukd_pkg::ukd_report_t report
);
	import ukd_pkg::*;

	logic [3:0]       prev_buttons_q;
	logic [3:0][31:0] last_change_q;
	logic [3:0][31:0] diff;
	logic [3:0]       pass;
	logic [3:0]       released;

	always_comb begin
		for (int b = 0; b < 4; b++) begin
			// wrap-aware: elapsed minus debounce must be positive as a signed value
			diff[b] = now_ticks - last_change_q[b] - {16'd0, debounce_ticks};
			pass[b] = apply && (buttons[b] != prev_buttons_q[b]) &&
				(diff[b] != 32'd0) && !diff[b][31];
		end
	end

	assign released      = press_only ? (pass & ~buttons) : 4'd0;
	assign report.mask   = pass[2:0];
	assign report.levels = pass[2:0] & buttons[2:0];
	assign report.power  = pass[3];
	assign report.syncs  = {2'b00, released[0]} + {2'b00, released[1]} +
		{2'b00, released[2]} + {2'b00, released[3]};
	assign report.sync   = |pass;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_buttons_q <= '0;
			last_change_q  <= '0;
		end else if (en) begin
			for (int b = 0; b < 4; b++) begin
				if (pass[b])
					last_change_q[b] <= now_ticks;
			end
			if (|pass)
				prev_buttons_q <= buttons;
		end
	end

endmodule
